// ===== rtl/sap_pkg.sv =====
// Shared types, constants and helpers for the S-curve acceleration profile sampler.
// No dependencies; imported by sap_pre and scurve_accel_profile_sampler.
`default_nettype none

package sap_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QW            = 62;

  typedef logic [QW-1:0]        uq_t;
  typedef logic signed [QW:0]   sq_t;

  localparam uq_t SATV = '1;
  localparam logic signed [63:0] SATS = 64'sh3FFF_FFFF_FFFF_FFFF;

  // ceil(2^64 / 3): floor(n * RECIP3 / 2^64) == floor(n / 3) for n < 2^61
  localparam logic [63:0] RECIP3 = 64'h5555_5555_5555_5556;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ACCEL = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] CFG_START_VEL   = 3'd0;
  localparam logic [2:0] CFG_TOP_VEL     = 3'd1;
  localparam logic [2:0] CFG_MAX_ACCEL   = 3'd2;
  localparam logic [2:0] CFG_ENTRY_ACCEL = 3'd3;
  localparam logic [2:0] CFG_EXIT_ACCEL  = 3'd4;

  typedef struct packed {
    logic [31:0] start_velocity;
    logic [31:0] top_velocity;
    logic [31:0] max_accel;
    logic [31:0] entry_accel;
    logic [31:0] exit_accel;
  } cfg_t;

  // profile constants handed from the setup sequencer to the sample pipeline
  typedef struct packed {
    logic        busy;
    logic [1:0]  status;
    uq_t         jm;
    uq_t         ts;
    uq_t         conc;
    uq_t         cs3;
    logic [62:0] ct;
    sq_t         sce;
    sq_t         vh;
  } prof_t;

  function automatic sq_t sadd(sq_t a, sq_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    if (s > SATS) return 63'(SATS);
    if (s < -SATS) return 63'(-SATS);
    return 63'(s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sap_mul.sv =====
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
// Standalone; each stage has its own load enable so it follows the pipeline stalls.
`default_nettype none

module sap_mul (
  input  logic         clk,
  input  logic         en_a,
  input  logic         en_b,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] p
);

  logic [63:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [127:0] p_nxt, p_r;

  always_ff @(posedge clk) begin
    if (en_a) begin
      pp00_r <= 64'(a[31:0])  * 64'(b[31:0]);
      pp01_r <= 64'(a[31:0])  * 64'(b[63:32]);
      pp10_r <= 64'(a[63:32]) * 64'(b[31:0]);
      pp11_r <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  assign p_nxt = {64'd0, pp00_r} + {32'd0, pp01_r, 32'd0} + {32'd0, pp10_r, 32'd0}
               + {pp11_r, 64'd0};

  always_ff @(posedge clk) begin
    if (en_b) p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ===== rtl/sap_pre.sv =====
// Profile setup sequencer: derives the curve constants from the configuration
// with one serial multiply-divide unit. Depends on sap_pkg.
`default_nettype none

module sap_pre
  import sap_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  cfg_we,
  output prof_t prof
);

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

  localparam logic [3:0] P_TH   = 4'd0;
  localparam logic [3:0] P_JM   = 4'd1;
  localparam logic [3:0] P_TS   = 4'd2;
  localparam logic [3:0] P_TE   = 4'd3;
  localparam logic [3:0] P_CT   = 4'd4;
  localparam logic [3:0] P_C1   = 4'd5;
  localparam logic [3:0] P_C2   = 4'd6;
  localparam logic [3:0] P_C3   = 4'd7;
  localparam logic [3:0] P_H1   = 4'd8;
  localparam logic [3:0] P_H2   = 4'd9;
  localparam logic [3:0] P_H3   = 4'd10;
  localparam logic [3:0] P_D6   = 4'd11;
  localparam logic [3:0] P_VC   = 4'd12;
  localparam logic [3:0] P_VH   = 4'd13;
  localparam logic [3:0] P_DONE = 4'd14;

  localparam logic [7:0] MUL_LAST = 8'd63;
  localparam logic [7:0] DIV_LAST = 8'd191;

  logic [3:0]   step_r;
  logic         run_r;
  logic [7:0]   cnt_r;
  logic [127:0] prod_r;
  logic [63:0]  rem_r;
  uq_t          quo_r;
  logic         ov_r;
  uq_t          th_r, jm_r, ts_r, te_r, conc_r, tmp_r, cs3_r, h2_r;
  logic [62:0]  ct_r;
  sq_t          sce_r, vh_r;

  logic [32:0]  as_w;
  logic [31:0]  dv_w;
  logic [63:0]  op_a, op_b, op_c;
  logic         alu_step;
  logic [64:0]  hi_sum, rem_sh, rem_sub;
  logic         ge;
  uq_t          quo_sh, res;
  logic         ov_sh;
  uq_t          conc_w;
  logic [62:0]  ct_w;
  logic [1:0]   stat_w;
  logic         use_div;
  logic [7:0]   last_w;
  logic [127:0] prod_nxt, prod_q;
  uq_t          mres, fin;

  assign as_w = {cfg.max_accel, 1'b0};
  assign dv_w = cfg.top_velocity - cfg.start_velocity;

  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = '0;
    unique case (step_r)
      P_TH: begin op_a = {32'd0, dv_w};  op_b = ONE;  op_c = {31'd0, as_w}; end
      P_JM: begin op_a = {31'd0, as_w};  op_b = {31'd0, as_w};  op_c = {32'd0, dv_w}; end
      P_TS: begin
        op_a = {2'd0, th_r};  op_b = {32'd0, cfg.entry_accel};  op_c = {31'd0, as_w};
      end
      P_TE: begin
        op_a = {2'd0, th_r};
        op_b = {31'd0, as_w} - {32'd0, cfg.exit_accel};
        op_c = {31'd0, as_w};
      end
      P_C1: begin op_a = {2'd0, jm_r};  op_b = {2'd0, ts_r};  op_c = ONE; end
      P_C2, P_C3: begin op_a = {2'd0, tmp_r};  op_b = {2'd0, ts_r};  op_c = ONE; end
      P_H1: begin op_a = {2'd0, jm_r};  op_b = {2'd0, th_r};  op_c = ONE; end
      P_H2, P_H3: begin op_a = {2'd0, tmp_r};  op_b = {2'd0, th_r};  op_c = ONE; end
      P_D6: begin op_a = {3'd0, tmp_r[QW-1:1]};  op_b = RECIP3; end
      P_VC: begin
        op_a = {32'd0, cfg.start_velocity};  op_b = {2'd0, conc_r};  op_c = ONE;
      end
      default: begin
        op_a = '0;
        op_b = '0;
        op_c = '0;
      end
    endcase
  end

  assign alu_step = (step_r == P_CT) || (step_r == P_VH);

  // only the profile quotients need the divide phase
  assign use_div = (step_r == P_TH) || (step_r == P_JM) || (step_r == P_TS)
                || (step_r == P_TE);
  assign last_w  = use_div ? DIV_LAST : MUL_LAST;

  // multiply phase: shift-add, one multiplier bit per cycle
  assign hi_sum   = {1'b0, prod_r[127:64]} + (prod_r[0] ? {1'b0, op_a} : 65'd0);
  assign prod_nxt = {hi_sum, prod_r[63:1]};

  // fixed-point products drop the fraction bits; the P_D6 step is a reciprocal product
  assign prod_q = prod_nxt >> FRAC_BITS;
  assign mres   = (step_r == P_D6) ? prod_nxt[64 +: QW]
                : ((|prod_q[127:QW]) ? SATV : prod_q[QW-1:0]);

  // divide phase: restoring, one dividend bit per cycle
  assign rem_sh  = {rem_r, prod_r[127]};
  assign ge      = rem_sh >= {1'b0, op_c};
  assign rem_sub = rem_sh - {1'b0, op_c};
  assign quo_sh  = {quo_r[QW-2:0], ge};
  assign ov_sh   = ov_r | quo_r[QW-1];
  assign res     = ov_sh ? SATV : quo_sh;

  assign fin = use_div ? res : mres;

  assign conc_w = th_r - ts_r;
  assign ct_w   = {1'b0, conc_w} + {1'b0, te_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= P_TH;
      run_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (cfg_we) begin
      step_r <= P_TH;
      run_r  <= 1'b0;
    end else if (step_r != P_DONE) begin
      if (alu_step) begin
        step_r <= step_r + 4'd1;
      end else if (!run_r) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 8'd1;
        if (cnt_r == last_w) begin
          run_r  <= 1'b0;
          step_r <= step_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!cfg_we && step_r != P_DONE) begin
      if (alu_step) begin
        if (step_r == P_CT) begin
          conc_r <= conc_w;
          ct_r   <= ct_w;
        end else begin
          vh_r <= sadd($signed({31'd0, cfg.start_velocity}), $signed({2'd0, h2_r[QW-1:1]}));
        end
      end else if (!run_r) begin
        prod_r <= {64'd0, op_b};
        rem_r  <= '0;
        quo_r  <= '0;
        ov_r   <= 1'b0;
      end else begin
        if (cnt_r <= MUL_LAST) begin
          prod_r <= prod_nxt;
        end else begin
          prod_r <= {prod_r[126:0], 1'b0};
          rem_r  <= ge ? rem_sub[63:0] : rem_sh[63:0];
          quo_r  <= quo_sh;
          ov_r   <= ov_sh;
        end
        if (cnt_r == last_w) begin
          case (step_r)
            P_TH: th_r <= fin;
            P_JM: jm_r <= fin;
            P_TS: ts_r <= (cfg.entry_accel != 32'd0) ? fin : '0;
            P_TE: te_r <= (cfg.exit_accel != 32'd0) ? fin : th_r;
            P_C1, P_C2, P_H1, P_D6: tmp_r <= fin;
            P_C3: cs3_r <= fin;
            P_H2: begin
              tmp_r <= fin;
              h2_r  <= fin;
            end
            P_H3: tmp_r <= (fin == SATV) ? SATV : fin - cs3_r;
            P_VC: sce_r <= sadd($signed({1'b0, fin}), $signed({1'b0, tmp_r}));
            default: ;
          endcase
        end
      end
    end
  end

  always_comb begin
    if ({1'b0, cfg.entry_accel} > as_w || {1'b0, cfg.exit_accel} > as_w)
      stat_w = ST_ACCEL;
    else if (cfg.top_velocity <= cfg.start_velocity || cfg.max_accel == 32'd0)
      stat_w = ST_DEGEN;
    else
      stat_w = ST_OK;
  end

  assign prof.busy   = step_r != P_DONE;
  assign prof.status = stat_w;
  assign prof.jm     = jm_r;
  assign prof.ts     = ts_r;
  assign prof.conc   = conc_r;
  assign prof.cs3    = cs3_r;
  assign prof.ct     = ct_r;
  assign prof.sce    = sce_r;
  assign prof.vh     = vh_r;

endmodule

`default_nettype wire

// ===== rtl/scurve_accel_profile_sampler.sv =====
// Top level of the S-curve acceleration profile sampler: config registers,
// ten-stage sample pipeline. Depends on sap_pkg, sap_mul and sap_pre.
//
// Takes one query time per cycle while in_ready is high and returns displacement,
// velocity, acceleration, curve time and status from the last pipeline stage;
// the four chained two-stage multipliers set the pipeline depth. Stalls on the
// output back up stage by stage, so bubbles still fill. After reset and after
// every configuration write the curve constants are recomputed by a serial
// multiply-divide unit (4 divides, 8 multiplies and 2 add-subtract steps);
// in_ready stays low while it runs.
`default_nettype none

module scurve_accel_profile_sampler
  import sap_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_query_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_displacement,
  output logic signed [31:0] out_velocity,
  output logic signed [31:0] out_acceleration,
  output logic [31:0]        out_curve_time,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam logic [31:0] ONE32 = 32'(64'd1 << FRAC_BITS);

  function automatic uq_t qsat(logic [127:0] p);
    logic [127:0] sh;
    sh = p >> FRAC_BITS;
    return (|sh[127:QW]) ? SATV : sh[QW-1:0];
  endfunction

  function automatic logic signed [47:0] clamp48(sq_t v);
    if (&v[QW:47] || ~|v[QW:47]) return v[47:0];
    return v[QW] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
  endfunction

  function automatic logic signed [31:0] clamp32(sq_t v);
    if (&v[QW:31] || ~|v[QW:31]) return v[31:0];
    return v[QW] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  cfg_t  cfg_r;
  prof_t prof;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_velocity <= '0;
      cfg_r.top_velocity   <= ONE32;
      cfg_r.max_accel      <= ONE32;
      cfg_r.entry_accel    <= '0;
      cfg_r.exit_accel     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_VEL:   cfg_r.start_velocity <= cfg_wdata;
        CFG_TOP_VEL:     cfg_r.top_velocity   <= cfg_wdata;
        CFG_MAX_ACCEL:   cfg_r.max_accel      <= cfg_wdata;
        CFG_ENTRY_ACCEL: cfg_r.entry_accel    <= cfg_wdata;
        CFG_EXIT_ACCEL:  cfg_r.exit_accel     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sap_pre #(.FRAC_BITS(FRAC_BITS)) u_pre (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .cfg_we (cfg_we),
    .prof   (prof)
  );

  logic [32:0] as_w;
  sq_t         as63, vo63;
  assign as_w = {cfg_r.max_accel, 1'b0};
  assign as63 = $signed({30'd0, as_w});
  assign vo63 = $signed({31'd0, cfg_r.start_velocity});

  // stall chain
  logic [10:1] v_r;
  logic [10:1] en;

  always_comb begin
    en[10] = !v_r[10] || out_ready;
    for (int k = 9; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_ready = en[1] && !prof.busy && !cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_valid && in_ready;
      for (int k = 2; k <= 10; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 0: phase select and status
  logic        conc_q, beyond;
  logic [62:0] x_sum;
  uq_t         x_dif, x0;
  logic [1:0]  st0;

  assign conc_q = {30'd0, in_query_time} < prof.conc;
  assign beyond = {31'd0, in_query_time} > prof.ct;
  assign x_sum  = {31'd0, in_query_time} + {1'b0, prof.ts};
  assign x_dif  = {30'd0, in_query_time} - prof.conc;
  assign x0     = conc_q ? x_sum[QW-1:0] : x_dif;
  assign st0    = (prof.status != ST_OK) ? prof.status : (beyond ? ST_RANGE : ST_OK);

  logic       cc1_r, cc2_r, cc3_r, cc4_r, cc5_r, cc6_r, cc7_r, cc8_r, cc9_r;
  logic [1:0] st1_r, st2_r, st3_r, st4_r, st5_r, st6_r, st7_r, st8_r, st9_r;
  uq_t        x1_r, x2_r, x3_r, x4_r, x5_r;
  uq_t        la1_r, lx1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cc1_r <= conc_q;
      st1_r <= st0;
      x1_r  <= x0;
      la1_r <= conc_q ? {30'd0, cfg_r.start_velocity} : prof.vh[QW-1:0];
      lx1_r <= conc_q ? {30'd0, in_query_time} : x0;
    end
    if (en[2]) begin cc2_r <= cc1_r; st2_r <= st1_r; x2_r <= x1_r; end
    if (en[3]) begin cc3_r <= cc2_r; st3_r <= st2_r; x3_r <= x2_r; end
  end

  // stages 2-3: J1 = jm*x, K1 = as*x, L = (vo*at | vh*u)
  logic [127:0] pj1, pk1, pl, pj2, pk2, pj3, p6;

  sap_mul u_mj1 (.clk(clk), .en_a(en[2]), .en_b(en[3]),
                 .a({2'd0, prof.jm}), .b({2'd0, x1_r}), .p(pj1));
  sap_mul u_mk1 (.clk(clk), .en_a(en[2]), .en_b(en[3]),
                 .a({31'd0, as_w}), .b({2'd0, x1_r}), .p(pk1));
  sap_mul u_ml  (.clk(clk), .en_a(en[2]), .en_b(en[3]),
                 .a({2'd0, la1_r}), .b({2'd0, lx1_r}), .p(pl));

  uq_t j1_w, k1_w, l_w;
  uq_t j1_4_r, k1_4_r, l4_r, j1_5_r, k1_5_r, l5_r;

  assign j1_w = qsat(pj1);
  assign k1_w = qsat(pk1);
  assign l_w  = qsat(pl);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      cc4_r <= cc3_r; st4_r <= st3_r; x4_r <= x3_r;
      j1_4_r <= j1_w; k1_4_r <= k1_w; l4_r <= l_w;
    end
    if (en[5]) begin
      cc5_r <= cc4_r; st5_r <= st4_r; x5_r <= x4_r;
      j1_5_r <= j1_4_r; k1_5_r <= k1_4_r; l5_r <= l4_r;
    end
  end

  // stages 4-5: J2 = J1*x, K2 = K1*x
  sap_mul u_mj2 (.clk(clk), .en_a(en[4]), .en_b(en[5]),
                 .a({2'd0, j1_w}), .b({2'd0, x3_r}), .p(pj2));
  sap_mul u_mk2 (.clk(clk), .en_a(en[4]), .en_b(en[5]),
                 .a({2'd0, k1_w}), .b({2'd0, x3_r}), .p(pk2));

  uq_t j2_w, k2_w;
  sq_t acc_w, sa_w, va_w;
  uq_t j2_6_r, k2_6_r;
  sq_t sa6_r, va6_r, acc6_r;

  assign j2_w  = qsat(pj2);
  assign k2_w  = qsat(pk2);
  assign acc_w = cc5_r ? $signed({1'b0, j1_5_r}) : as63 - $signed({1'b0, j1_5_r});
  assign sa_w  = cc5_r ? $signed({1'b0, l5_r}) : sadd(prof.sce, $signed({1'b0, l5_r}));
  assign va_w  = cc5_r ? sadd(vo63, $signed({2'd0, j2_w[QW-1:1]}))
                       : sadd(prof.vh, $signed({1'b0, k1_5_r}));

  always_ff @(posedge clk) begin
    if (en[6]) begin
      cc6_r <= cc5_r; st6_r <= st5_r;
      j2_6_r <= j2_w; k2_6_r <= k2_w;
      sa6_r <= sa_w; va6_r <= va_w; acc6_r <= acc_w;
    end
  end

  // stages 6-7: J3 = J2*x
  sap_mul u_mj3 (.clk(clk), .en_a(en[6]), .en_b(en[7]),
                 .a({2'd0, j2_w}), .b({2'd0, x5_r}), .p(pj3));

  sq_t sb_w, vb_w;
  sq_t sb7_r, vb7_r, acc7_r, sb8_r, vb8_r, acc8_r, sb9_r, vb9_r, acc9_r;

  assign sb_w = cc6_r ? sa6_r : sadd(sa6_r, $signed({2'd0, k2_6_r[QW-1:1]}));
  assign vb_w = cc6_r ? va6_r : va6_r - $signed({2'd0, j2_6_r[QW-1:1]});

  always_ff @(posedge clk) begin
    if (en[7]) begin
      cc7_r <= cc6_r; st7_r <= st6_r;
      sb7_r <= sb_w; vb7_r <= vb_w; acc7_r <= acc6_r;
    end
    if (en[8]) begin
      cc8_r <= cc7_r; st8_r <= st7_r;
      sb8_r <= sb7_r; vb8_r <= vb7_r; acc8_r <= acc7_r;
    end
    if (en[9]) begin
      cc9_r <= cc8_r; st9_r <= st8_r;
      sb9_r <= sb8_r; vb9_r <= vb8_r; acc9_r <= acc8_r;
    end
  end

  // stages 8-9: cube term over six, as (n/2) * ceil(2^64/3) >> 64
  uq_t j3_w, n_w;
  assign j3_w = qsat(pj3);
  assign n_w  = cc7_r ? ((j3_w == SATV) ? SATV : j3_w - prof.cs3) : j3_w;

  sap_mul u_m6 (.clk(clk), .en_a(en[8]), .en_b(en[9]),
                .a({3'd0, n_w[QW-1:1]}), .b(RECIP3), .p(p6));

  // stage 9 -> output register
  uq_t q6_w;
  sq_t s_w;
  logic [31:0] ct_sat;

  assign q6_w   = p6[64 +: QW];
  assign s_w    = cc9_r ? sadd(sb9_r, $signed({1'b0, q6_w})) : sb9_r - $signed({1'b0, q6_w});
  assign ct_sat = (|prof.ct[62:32]) ? 32'hFFFF_FFFF : prof.ct[31:0];

  logic signed [47:0] disp_r;
  logic signed [31:0] vel_r, acc_r;
  logic [31:0]        ct_r;
  logic [1:0]         st_r;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      st_r <= st9_r;
      if (st9_r == ST_OK) begin
        disp_r <= clamp48(s_w);
        vel_r  <= clamp32(vb9_r);
        acc_r  <= clamp32(acc9_r);
      end else begin
        disp_r <= '0;
        vel_r  <= '0;
        acc_r  <= '0;
      end
      ct_r <= (st9_r == ST_ACCEL || st9_r == ST_DEGEN) ? 32'd0 : ct_sat;
    end
  end

  assign out_valid        = v_r[10];
  assign out_displacement = disp_r;
  assign out_velocity     = vel_r;
  assign out_acceleration = acc_r;
  assign out_curve_time   = ct_r;
  assign out_status       = st_r;

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken while profile constants recompute");

  a_bad_profile_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ACCEL || out_status == ST_DEGEN) |->
      out_curve_time == 32'd0 && out_displacement == 48'sd0)
    else $error("rejected profile beat carries data");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RANGE |->
      out_displacement == 48'sd0 && out_velocity == 32'sd0 && out_acceleration == 32'sd0)
    else $error("out-of-range beat carries motion data");

endmodule

`default_nettype wire
